/* src/cau_pkg.sv */
package cau_pkg;

    typedef enum logic [1:0]
    {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // control that travels from the front end through every divider stage
    typedef struct packed
    {
        logic valid;
        op_t  op;
        logic nan;
    } ctl_t;

endpackage

/* src/cau_front.sv */
module cau_front #(
    parameter int W         = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid,
    input  logic [1:0]           operation,
    input  logic [31:0]          a_real,
    input  logic [31:0]          a_imag,
    input  logic [31:0]          b_real,
    input  logic [31:0]          b_imag,
    output cau_pkg::ctl_t        ctl,
    output logic [2*W-1:0]       den,
    output logic                 re_neg,
    output logic                 re_cap,
    output logic [2*W-1:0]       re_rem,
    output logic [W+FRAC_BITS-2:0] re_qd,
    output logic signed [2*W+1:0] re_val,
    output logic                 im_neg,
    output logic                 im_cap,
    output logic [2*W-1:0]       im_rem,
    output logic [W+FRAC_BITS-2:0] im_qd,
    output logic signed [2*W+1:0] im_val
);

    localparam int NW = 2 * W;
    localparam int VW = 2 * W + 2;
    localparam int QB = W - 1 + FRAC_BITS;
    localparam int CW = NW + W - 1;

    // stage 0: operand capture
    logic                v0_reg;
    cau_pkg::op_t        op0_reg;
    logic signed [W-1:0] a0_reg, b0_reg, c0_reg, d0_reg;

    // stage 1: products and add/sub
    logic                 v1_reg;
    cau_pkg::op_t         op1_reg;
    logic signed [NW-1:0] ac1_reg, bd1_reg, ad1_reg, bc1_reg, cc1_reg, dd1_reg;
    logic signed [VW-1:0] vre1_reg, vim1_reg;

    // stage 2: sums of products
    logic                 v2_reg;
    cau_pkg::op_t         op2_reg;
    logic signed [NW:0]   sre2_reg, sim2_reg;
    logic [NW-1:0]        den2_reg;
    logic signed [VW-1:0] vre2_reg, vim2_reg;

    // stage 3 outputs
    cau_pkg::ctl_t        ctl_reg;
    logic [NW-1:0]        den_reg;
    logic                 re_neg_reg, re_cap_reg, im_neg_reg, im_cap_reg;
    logic [NW-1:0]        re_rem_reg, im_rem_reg;
    logic [QB-1:0]        re_qd_reg, im_qd_reg;
    logic signed [VW-1:0] re_val_reg, im_val_reg;

    logic signed [VW-1:0] xre, xim;
    logic [NW:0]          mre, mim;
    logic [CW-1:0]        denx;
    logic                 nre, nim;

    always_comb
    begin
        xre  = VW'(sre2_reg);
        xim  = VW'(sim2_reg);
        nre  = sre2_reg[NW];
        nim  = sim2_reg[NW];
        mre  = nre ? $unsigned(-sre2_reg) : $unsigned(sre2_reg);
        mim  = nim ? $unsigned(-sim2_reg) : $unsigned(sim2_reg);
        denx = CW'(den2_reg) << (W - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v0_reg        <= valid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            ctl_reg.valid <= v2_reg;
            ctl_reg.op    <= op2_reg;
            ctl_reg.nan   <= (op2_reg == cau_pkg::OP_DIV) && (den2_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg <= cau_pkg::op_t'(operation);
            a0_reg  <= a_real[W-1:0];
            b0_reg  <= a_imag[W-1:0];
            c0_reg  <= b_real[W-1:0];
            d0_reg  <= b_imag[W-1:0];

            op1_reg <= op0_reg;
            ac1_reg <= a0_reg * c0_reg;
            bd1_reg <= b0_reg * d0_reg;
            ad1_reg <= a0_reg * d0_reg;
            bc1_reg <= b0_reg * c0_reg;
            cc1_reg <= c0_reg * c0_reg;
            dd1_reg <= d0_reg * d0_reg;
            if (op0_reg == cau_pkg::OP_SUB)
            begin
                vre1_reg <= VW'(a0_reg) - VW'(c0_reg);
                vim1_reg <= VW'(b0_reg) - VW'(d0_reg);
            end
            else
            begin
                vre1_reg <= VW'(a0_reg) + VW'(c0_reg);
                vim1_reg <= VW'(b0_reg) + VW'(d0_reg);
            end

            op2_reg  <= op1_reg;
            vre2_reg <= vre1_reg;
            vim2_reg <= vim1_reg;
            den2_reg <= $unsigned(cc1_reg) + $unsigned(dd1_reg);
            if (op1_reg == cau_pkg::OP_DIV)
            begin
                sre2_reg <= (NW+1)'(ac1_reg) + (NW+1)'(bd1_reg);
                sim2_reg <= (NW+1)'(bc1_reg) - (NW+1)'(ad1_reg);
            end
            else
            begin
                sre2_reg <= (NW+1)'(ac1_reg) - (NW+1)'(bd1_reg);
                sim2_reg <= (NW+1)'(ad1_reg) + (NW+1)'(bc1_reg);
            end

            // floor shift for multiply, sign and magnitude for divide
            den_reg    <= den2_reg;
            re_val_reg <= (op2_reg == cau_pkg::OP_MUL) ? (xre >>> FRAC_BITS) : vre2_reg;
            im_val_reg <= (op2_reg == cau_pkg::OP_MUL) ? (xim >>> FRAC_BITS) : vim2_reg;
            re_neg_reg <= nre;
            im_neg_reg <= nim;
            re_cap_reg <= CW'(mre[NW-1:0]) >= denx;
            im_cap_reg <= CW'(mim[NW-1:0]) >= denx;
            re_rem_reg <= NW'(mre[NW-1:0] >> (W - 1));
            im_rem_reg <= NW'(mim[NW-1:0] >> (W - 1));
            re_qd_reg  <= QB'(mre[W-2:0]) << FRAC_BITS;
            im_qd_reg  <= QB'(mim[W-2:0]) << FRAC_BITS;
        end
    end

    assign ctl    = ctl_reg;
    assign den    = den_reg;
    assign re_neg = re_neg_reg;
    assign re_cap = re_cap_reg;
    assign re_rem = re_rem_reg;
    assign re_qd  = re_qd_reg;
    assign re_val = re_val_reg;
    assign im_neg = im_neg_reg;
    assign im_cap = im_cap_reg;
    assign im_rem = im_rem_reg;
    assign im_qd  = im_qd_reg;
    assign im_val = im_val_reg;

endmodule

/* src/cau_div_step.sv */
module cau_div_step #(
    parameter int W         = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  cau_pkg::ctl_t          ctl_i,
    input  logic [2*W-1:0]         den_i,
    input  logic                   re_neg_i,
    input  logic                   re_cap_i,
    input  logic [2*W-1:0]         re_rem_i,
    input  logic [W+FRAC_BITS-2:0] re_qd_i,
    input  logic signed [2*W+1:0]  re_val_i,
    input  logic                   im_neg_i,
    input  logic                   im_cap_i,
    input  logic [2*W-1:0]         im_rem_i,
    input  logic [W+FRAC_BITS-2:0] im_qd_i,
    input  logic signed [2*W+1:0]  im_val_i,
    output cau_pkg::ctl_t          ctl_o,
    output logic [2*W-1:0]         den_o,
    output logic                   re_neg_o,
    output logic                   re_cap_o,
    output logic [2*W-1:0]         re_rem_o,
    output logic [W+FRAC_BITS-2:0] re_qd_o,
    output logic signed [2*W+1:0]  re_val_o,
    output logic                   im_neg_o,
    output logic                   im_cap_o,
    output logic [2*W-1:0]         im_rem_o,
    output logic [W+FRAC_BITS-2:0] im_qd_o,
    output logic signed [2*W+1:0]  im_val_o
);

    localparam int NW = 2 * W;
    localparam int VW = 2 * W + 2;
    localparam int QB = W - 1 + FRAC_BITS;

    cau_pkg::ctl_t        ctl_reg;
    logic [NW-1:0]        den_reg;
    logic                 re_neg_reg, re_cap_reg, im_neg_reg, im_cap_reg;
    logic [NW-1:0]        re_rem_reg, im_rem_reg;
    logic [QB-1:0]        re_qd_reg, im_qd_reg;
    logic signed [VW-1:0] re_val_reg, im_val_reg;

    logic [NW+QB-1:0]     re_next, im_next;

    // one restoring step: bring down the next dividend bit, shift in a quotient bit
    function automatic logic [NW+QB-1:0] step(input logic [NW-1:0] rem,
                                              input logic [QB-1:0] qd,
                                              input logic [NW-1:0] d);
        logic [NW:0] t;
        logic        ge;
        t  = {rem, qd[QB-1]};
        ge = t >= {1'b0, d};
        if (ge)
        begin
            t = t - {1'b0, d};
        end
        return {t[NW-1:0], qd[QB-2:0], ge};
    endfunction

    always_comb
    begin
        re_next = step(re_rem_i, re_qd_i, den_i);
        im_next = step(im_rem_i, im_qd_i, den_i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg    <= den_i;
            re_neg_reg <= re_neg_i;
            re_cap_reg <= re_cap_i;
            re_val_reg <= re_val_i;
            re_rem_reg <= re_next[NW+QB-1:QB];
            re_qd_reg  <= re_next[QB-1:0];
            im_neg_reg <= im_neg_i;
            im_cap_reg <= im_cap_i;
            im_val_reg <= im_val_i;
            im_rem_reg <= im_next[NW+QB-1:QB];
            im_qd_reg  <= im_next[QB-1:0];
        end
    end

    assign ctl_o    = ctl_reg;
    assign den_o    = den_reg;
    assign re_neg_o = re_neg_reg;
    assign re_cap_o = re_cap_reg;
    assign re_rem_o = re_rem_reg;
    assign re_qd_o  = re_qd_reg;
    assign re_val_o = re_val_reg;
    assign im_neg_o = im_neg_reg;
    assign im_cap_o = im_cap_reg;
    assign im_rem_o = im_rem_reg;
    assign im_qd_o  = im_qd_reg;
    assign im_val_o = im_val_reg;

endmodule

/* src/cau_sat.sv */
module cau_sat #(
    parameter int W         = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  cau_pkg::ctl_t          ctl,
    input  logic                   re_neg,
    input  logic                   re_cap,
    input  logic [W+FRAC_BITS-2:0] re_qd,
    input  logic signed [2*W+1:0]  re_val,
    input  logic                   im_neg,
    input  logic                   im_cap,
    input  logic [W+FRAC_BITS-2:0] im_qd,
    input  logic signed [2*W+1:0]  im_val,
    output logic                   valid,
    output logic [31:0]            res_real,
    output logic [31:0]            res_imag,
    output logic                   nan_flag,
    output logic                   overflow_flag
);

    localparam int VW = 2 * W + 2;
    localparam int QB = W - 1 + FRAC_BITS;
    localparam logic [W-1:0] POS_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_W = {1'b1, {(W-1){1'b0}}};

    logic        valid_reg;
    logic [31:0] res_real_reg, res_imag_reg;
    logic        nan_reg, ovf_reg;

    logic [W:0]  sre, sim;
    logic        is_div;

    // returns {overflow, word}
    function automatic logic [W:0] sat_lane(input logic div, input logic neg,
                                            input logic cap, input logic [QB-1:0] q,
                                            input logic signed [VW-1:0] v);
        logic [QB:0] qx;
        qx = {1'b0, q};
        if (div)
        begin
            priority if (!neg && (cap || qx > (QB+1)'(POS_W)))
                return {1'b1, POS_W};
            else if (neg && (cap || qx > (QB+1)'(NEG_W)))
                return {1'b1, NEG_W};
            else if (neg)
                return {1'b0, W'(-qx)};
            else
                return {1'b0, qx[W-1:0]};
        end
        priority if (v > $signed(VW'(POS_W)))
            return {1'b1, POS_W};
        else if (v < $signed({{(VW-W){1'b1}}, NEG_W}))
            return {1'b1, NEG_W};
        else
            return {1'b0, v[W-1:0]};
    endfunction

    always_comb
    begin
        is_div = ctl.op == cau_pkg::OP_DIV;
        sre    = sat_lane(is_div, re_neg, re_cap, re_qd, re_val);
        sim    = sat_lane(is_div, im_neg, im_cap, im_qd, im_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ctl.nan)
            begin
                res_real_reg <= '0;
                res_imag_reg <= '0;
                ovf_reg      <= 1'b0;
            end
            else
            begin
                res_real_reg <= 32'($signed(sre[W-1:0]));
                res_imag_reg <= 32'($signed(sim[W-1:0]));
                ovf_reg      <= sre[W] | sim[W];
            end
            nan_reg <= ctl.nan;
        end
    end

    assign valid         = valid_reg;
    assign res_real      = res_real_reg;
    assign res_imag      = res_imag_reg;
    assign nan_flag      = nan_reg;
    assign overflow_flag = ovf_reg;

endmodule

/* src/complex_arithmetic_unit.sv */
// complex arithmetic unit: add, subtract, multiply or divide two complex
// operands in signed fixed point (WORD_BITS bits, FRAC_BITS fraction bits)
//
// request channel: req_valid / req_stall with operation, a_real, a_imag,
//   b_real, b_imag; a transaction completes when req_valid is high and
//   req_stall is low at a rising edge
// response channel: rsp_valid / rsp_stall with res_real, res_imag,
//   nan_flag, overflow_flag; one response per request, in order
// throughput: one transaction per cycle, every operation alike, unless a
//   response is held with rsp_stall high; the restoring divider retires
//   one quotient bit per stage; W = min(WORD_BITS, 32) is the word width
// stall: the whole pipeline advances together; while a response waits with
//   rsp_stall high every stage holds and req_stall is raised, nothing is
//   dropped or repeated, and bubbles travel as invalid stages
// reset: rst_n clears all valid bits at once, the pipeline is empty and
//   ready for a request on the first cycle after reset
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  operation,
    input  logic [31:0] a_real,
    input  logic [31:0] a_imag,
    input  logic [31:0] b_real,
    input  logic [31:0] b_imag,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] res_real,
    output logic [31:0] res_imag,
    output logic        nan_flag,
    output logic        overflow_flag
);

    // field width caps the arithmetic word
    localparam int W  = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int NW = 2 * W;
    localparam int VW = 2 * W + 2;
    localparam int QB = W - 1 + FRAC_BITS;

    // one enable for every stage: advance unless the held response is stalled
    logic en;
    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    // per-stage signals of the divider chain, index 0 is the front end output
    cau_pkg::ctl_t        ctl_s    [QB+1];
    logic [NW-1:0]        den_s    [QB+1];
    logic                 re_neg_s [QB+1];
    logic                 re_cap_s [QB+1];
    logic [NW-1:0]        re_rem_s [QB+1];
    logic [QB-1:0]        re_qd_s  [QB+1];
    logic signed [VW-1:0] re_val_s [QB+1];
    logic                 im_neg_s [QB+1];
    logic                 im_cap_s [QB+1];
    logic [NW-1:0]        im_rem_s [QB+1];
    logic [QB-1:0]        im_qd_s  [QB+1];
    logic signed [VW-1:0] im_val_s [QB+1];

    // operand capture, products, sums, divide setup and overflow precheck
    cau_front #(
        .W         (W),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (req_valid),
        .operation (operation),
        .a_real    (a_real),
        .a_imag    (a_imag),
        .b_real    (b_real),
        .b_imag    (b_imag),
        .ctl       (ctl_s[0]),
        .den       (den_s[0]),
        .re_neg    (re_neg_s[0]),
        .re_cap    (re_cap_s[0]),
        .re_rem    (re_rem_s[0]),
        .re_qd     (re_qd_s[0]),
        .re_val    (re_val_s[0]),
        .im_neg    (im_neg_s[0]),
        .im_cap    (im_cap_s[0]),
        .im_rem    (im_rem_s[0]),
        .im_qd     (im_qd_s[0]),
        .im_val    (im_val_s[0])
    );

    // divider: one quotient bit per stage for both parts; other operations
    // ride along unchanged in the val fields
    for (genvar i = 0; i < QB; i++)
    begin : g_div
        cau_div_step #(
            .W         (W),
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_i    (ctl_s[i]),
            .den_i    (den_s[i]),
            .re_neg_i (re_neg_s[i]),
            .re_cap_i (re_cap_s[i]),
            .re_rem_i (re_rem_s[i]),
            .re_qd_i  (re_qd_s[i]),
            .re_val_i (re_val_s[i]),
            .im_neg_i (im_neg_s[i]),
            .im_cap_i (im_cap_s[i]),
            .im_rem_i (im_rem_s[i]),
            .im_qd_i  (im_qd_s[i]),
            .im_val_i (im_val_s[i]),
            .ctl_o    (ctl_s[i+1]),
            .den_o    (den_s[i+1]),
            .re_neg_o (re_neg_s[i+1]),
            .re_cap_o (re_cap_s[i+1]),
            .re_rem_o (re_rem_s[i+1]),
            .re_qd_o  (re_qd_s[i+1]),
            .re_val_o (re_val_s[i+1]),
            .im_neg_o (im_neg_s[i+1]),
            .im_cap_o (im_cap_s[i+1]),
            .im_rem_o (im_rem_s[i+1]),
            .im_qd_o  (im_qd_s[i+1]),
            .im_val_o (im_val_s[i+1])
        );
    end

    // saturation, divide-by-zero handling and the response register;
    // the final remainder and divisor are not needed past the divider
    cau_sat #(
        .W         (W),
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .ctl           (ctl_s[QB]),
        .re_neg        (re_neg_s[QB]),
        .re_cap        (re_cap_s[QB]),
        .re_qd         (re_qd_s[QB]),
        .re_val        (re_val_s[QB]),
        .im_neg        (im_neg_s[QB]),
        .im_cap        (im_cap_s[QB]),
        .im_qd         (im_qd_s[QB]),
        .im_val        (im_val_s[QB]),
        .valid         (rsp_valid),
        .res_real      (res_real),
        .res_imag      (res_imag),
        .nan_flag      (nan_flag),
        .overflow_flag (overflow_flag)
    );

endmodule

/* src/cau_checker.sv */
module cau_checker #(
    parameter int WORD_BITS = 32
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [31:0] res_real,
    input logic [31:0] res_imag,
    input logic        nan_flag,
    input logic        overflow_flag
);

    localparam int W = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam logic [W-1:0] POS_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_W = {1'b1, {(W-1){1'b0}}};
    localparam logic [31:0]  POS   = 32'($signed(POS_W));
    localparam logic [31:0]  NEG   = 32'($signed(NEG_W));

    // a held response backs up into the request side
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
    else $error("request side not stalled behind a held response");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(res_real) && $stable(res_imag)
            && $stable(nan_flag) && $stable(overflow_flag))
    else $error("stalled response changed");

    // divide by zero gives a clean zero result
    a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && nan_flag |-> res_real == '0 && res_imag == '0 && !overflow_flag)
    else $error("divide by zero response not zero");

    // an overflow leaves at least one part pinned at a limit
    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && overflow_flag |-> res_real == POS || res_real == NEG
            || res_imag == POS || res_imag == NEG)
    else $error("overflow without a saturated part");

endmodule

bind complex_arithmetic_unit cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (.*);
